FILE: rtl/tpa_pkg.sv
// Package with shared constants and types for the tanh core.
package tpa_pkg;
	localparam int IN_FRAC_BITS_DEF = 12;
	localparam int OUT_FRAC_BITS_DEF = 14;
	localparam int WORK_FRAC = 12;
	localparam logic [16:0] MAG_LIMIT = 17'd16384;
	localparam int X2_W = 21;
	localparam int POLY_W = 37;
	localparam int NUM_W = 49;
	localparam int DEN_W = 49;
	localparam logic [POLY_W-1:0] C_N1 = POLY_W'(64'd378 << 16);
	localparam logic [POLY_W-1:0] C_N2 = POLY_W'(64'd17325 << 16);
	localparam logic [POLY_W-1:0] C_N3 = POLY_W'(64'd135135 << 16);
	localparam logic [POLY_W-1:0] C_D1 = POLY_W'(64'd3150 << 16);
	localparam logic [POLY_W-1:0] C_D2 = POLY_W'(64'd62370 << 16);
	localparam logic [POLY_W-1:0] C_D3 = POLY_W'(64'd135135 << 16);
	localparam logic [POLY_W-1:0] C_28 = POLY_W'(28);

	typedef struct packed {
		logic valid;
		logic neg;
	} ctl_t;
endpackage

FILE: rtl/tpa_div_cell.sv
// One restoring division cell: produces one quotient bit per stage.
module tpa_div_cell #(
	parameter int Q_W = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  tpa_pkg::ctl_t ctl_in,
	input  logic [tpa_pkg::DEN_W:0] rem_in,
	input  logic [tpa_pkg::DEN_W-1:0] den_in,
	input  logic [Q_W-1:0] q_in,
	output tpa_pkg::ctl_t ctl_out,
	output logic [tpa_pkg::DEN_W:0] rem_out,
	output logic [tpa_pkg::DEN_W-1:0] den_out,
	output logic [Q_W-1:0] q_out
);
	logic [tpa_pkg::DEN_W+1:0] sh;
	logic ge;
	logic [tpa_pkg::DEN_W+1:0] diff;

	always_comb begin
		sh = {rem_in, 1'b0};
		diff = sh - {2'b0, den_in};
		ge = (sh >= {2'b0, den_in});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_out <= ge ? diff[tpa_pkg::DEN_W:0] : sh[tpa_pkg::DEN_W:0];
		den_out <= den_in;
		q_out <= {q_in[Q_W-2:0], ge};
	end
endmodule

FILE: rtl/tpa_poly.sv
// Front end: input alignment, square, both Horner chains and the numerator product.
module tpa_poly #(
	parameter int IN_FRAC_BITS = tpa_pkg::IN_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [15:0] x_in,
	output tpa_pkg::ctl_t ctl_out,
	output logic [tpa_pkg::NUM_W-1:0] num_out,
	output logic [tpa_pkg::DEN_W-1:0] den_out
);
	localparam int PW = tpa_pkg::POLY_W;
	localparam int XW = tpa_pkg::X2_W;
	localparam int SH = (IN_FRAC_BITS > tpa_pkg::WORK_FRAC) ? IN_FRAC_BITS - tpa_pkg::WORK_FRAC : 0;
	localparam int SL = (IN_FRAC_BITS < tpa_pkg::WORK_FRAC) ? tpa_pkg::WORK_FRAC - IN_FRAC_BITS : 0;

	logic [16:0] mag;
	logic [24:0] m_al;
	logic [16:0] m_c;
	tpa_pkg::ctl_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6;
	logic [16:0] m_s1, m_s2, m_s3, m_s4, m_s5;
	logic [XW-1:0] x2_s2, x2_s3, x2_s4;
	logic [PW-1:0] n_s3, d_s3, n_s4, d_s4, n_s5, d_s5;
	logic [33:0] sq;
	logic [2*PW-1:0] pn3, pd3, pn4, pd4;
	logic [PW-1:0] d1;

	always_comb begin
		mag = x_in[15] ? (17'h10000 - {1'b0, x_in}) : {1'b0, x_in};
		if (IN_FRAC_BITS > tpa_pkg::WORK_FRAC) begin
			m_al = ({8'b0, mag} + (25'd1 << (SH - 1))) >> SH;
		end else begin
			m_al = {8'b0, mag} << SL;
		end
		m_c = (m_al > {8'b0, tpa_pkg::MAG_LIMIT}) ? tpa_pkg::MAG_LIMIT : m_al[16:0];
		sq = m_s1 * m_s1 + 34'd128;
		d1 = tpa_pkg::C_D1 + tpa_pkg::C_28 * {{(PW-XW){1'b0}}, x2_s2};
		pn3 = {{(2*PW-XW){1'b0}}, x2_s3} * {{PW{1'b0}}, n_s3};
		pd3 = {{(2*PW-XW){1'b0}}, x2_s3} * {{PW{1'b0}}, d_s3};
		pn4 = {{(2*PW-XW){1'b0}}, x2_s4} * {{PW{1'b0}}, n_s4};
		pd4 = {{(2*PW-XW){1'b0}}, x2_s4} * {{PW{1'b0}}, d_s4};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0;
			c_s2 <= '0;
			c_s3 <= '0;
			c_s4 <= '0;
			c_s5 <= '0;
			c_s6 <= '0;
		end else begin
			c_s1 <= '{valid: in_valid, neg: x_in[15]};
			c_s2 <= c_s1;
			c_s3 <= c_s2;
			c_s4 <= c_s3;
			c_s5 <= c_s4;
			c_s6 <= c_s5;
		end
	end

	always_ff @(posedge clk) begin
		m_s1 <= m_c;
		m_s2 <= m_s1;
		x2_s2 <= sq[28:8];
		m_s3 <= m_s2;
		x2_s3 <= x2_s2;
		n_s3 <= tpa_pkg::C_N1 + {{(PW-XW){1'b0}}, x2_s2};
		d_s3 <= d1;
		m_s4 <= m_s3;
		x2_s4 <= x2_s3;
		n_s4 <= tpa_pkg::C_N2 + pn3[PW+15:16];
		d_s4 <= tpa_pkg::C_D2 + pd3[PW+15:16];
		m_s5 <= m_s4;
		n_s5 <= tpa_pkg::C_N3 + pn4[PW+15:16];
		d_s5 <= tpa_pkg::C_D3 + pd4[PW+15:16];
		den_out <= {d_s5, 12'b0};
		num_out <= {{(tpa_pkg::NUM_W-17){1'b0}}, m_s5} * {{(tpa_pkg::NUM_W-PW){1'b0}}, n_s5};
	end

	assign ctl_out = c_s6;
	logic unused_ok;
	assign unused_ok = ^{sq[33:29], sq[7:0]};
endmodule

FILE: rtl/tanh_pade_approx_core.sv
// Top level of the pipelined 7/6 Pade tanh core.
// Usage: drive x_in with start high; busy is always low, so a transfer
// happens in every cycle that start is high. One sample per clock is taken.
// Each result appears on tanh_out for exactly one cycle with done high.
// From the input transfer a result passes through the front-end registers for
// alignment, square, Horner products and numerator product, a register to split
// off the integer quotient bit, one division cell for each fraction bit and for
// the rounding bit, and a final rounding and saturation register.
// Throughput is one item per cycle; the division runs as a row of cells, each
// passing its partial remainder to the next cell on every clock.
// Results keep the input order. The receiver cannot stall, so every result
// leaves on its single strobe cycle.
// Reset clears all valid flags; items in flight at reset are dropped.
// There are no configuration registers.
module tanh_pade_approx_core #(
	parameter int IN_FRAC_BITS = tpa_pkg::IN_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = tpa_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [15:0] x_in,
	output logic done,
	output logic signed [15:0] tanh_out
);
	localparam int NC = OUT_FRAC_BITS + 1;
	localparam int QW = NC + 1;
	localparam int DW = tpa_pkg::DEN_W;

	tpa_pkg::ctl_t pc, c0;
	logic [tpa_pkg::NUM_W-1:0] num;
	logic [DW-1:0] den;
	logic [DW:0] r0;
	logic [DW-1:0] dd0;
	logic [QW-1:0] q0;
	logic ige;

	tpa_pkg::ctl_t cc[NC+1];
	logic [DW:0] rr[NC+1];
	logic [DW-1:0] dd[NC+1];
	logic [QW-1:0] qq[NC+1];

	logic [QW-1:0] qr;
	logic [QW-1:0] one;
	logic [QW-1:0] qs;
	logic [QW-1:0] res;

	assign busy = 1'b0;

	tpa_poly #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_poly (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .x_in(x_in),
		.ctl_out(pc), .num_out(num), .den_out(den)
	);

	assign ige = ({{(DW-tpa_pkg::NUM_W+1){1'b0}}, num} >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0 <= '0;
		end else begin
			c0 <= pc;
		end
	end

	always_ff @(posedge clk) begin
		r0 <= ige ? ({{(DW-tpa_pkg::NUM_W+1){1'b0}}, num} - {1'b0, den})
			: {{(DW-tpa_pkg::NUM_W+1){1'b0}}, num};
		dd0 <= den;
		q0 <= {{(QW-1){1'b0}}, ige};
	end

	assign cc[0] = c0;
	assign rr[0] = r0;
	assign dd[0] = dd0;
	assign qq[0] = q0;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		tpa_div_cell #(.Q_W(QW)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_in(cc[i]), .rem_in(rr[i]), .den_in(dd[i]), .q_in(qq[i]),
			.ctl_out(cc[i+1]), .rem_out(rr[i+1]), .den_out(dd[i+1]), .q_out(qq[i+1])
		);
	end

	always_comb begin
		qr = (qq[NC] + {{(QW-1){1'b0}}, 1'b1}) >> 1;
		one = {{(QW-1){1'b0}}, 1'b1} << OUT_FRAC_BITS;
		qs = (qr > one) ? one : qr;
		res = cc[NC].neg ? (~qs + {{(QW-1){1'b0}}, 1'b1}) : qs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cc[NC].valid;
		end
	end

	always_ff @(posedge clk) begin
		tanh_out <= 16'(signed'({cc[NC].neg & (qs != '0), res}));
	end

	logic unused_ok;
	assign unused_ok = ^{rr[NC], dd[NC]};

`ifndef SYNTHESIS
	a_busy_low: assert property (@(posedge clk) busy == 1'b0)
		else $error("busy must stay low");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cc[NC].valid |=> done)
		else $error("result strobe lost");
	a_zero_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(cc[NC].valid && qs == '0) |=> (done && tanh_out == 16'sd0))
		else $error("zero quotient must give zero result");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cc[NC].valid |-> (qs <= one))
		else $error("result above one");
`endif
endmodule
